// File: sv/assert_macros.svh
// Assertion macros for the height query unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property p holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, p) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (p)) \
        else $error("assertion failed");

// Whenever a holds, c holds in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`endif

// File: sv/hmtq_pkg.sv
// Types, constants and the divider step for the heightmap height query unit.
package hmtq_pkg;

    localparam int CoordW = 24;
    localparam int SizeW  = 16;
    localparam int QuotW  = 24;
    localparam int NumW   = 40;

    localparam logic [1:0] REG_CELL_SIZE    = 2'd0;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;
    localparam logic [1:0] REG_COLS_USED    = 2'd2;
    localparam logic [1:0] REG_ROWS_USED    = 2'd3;

    // Word in flight through the coordinate dividers.
    typedef struct packed {
        logic              is_q;
        logic              ins;
        logic [7:0]        col;
        logic [7:0]        row;
        logic [7:0]        raw;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] z;
        logic [QuotW-1:0]  qx;
        logic [QuotW-1:0]  qz;
        logic [SizeW-1:0]  rx;
        logic [SizeW-1:0]  rz;
    } coord_div_t;

    // Word in flight through the final rounding divider.
    typedef struct packed {
        logic             ins;
        logic [NumW-1:0]  num;
        logic [QuotW-1:0] q;
        logic [SizeW-1:0] r;
    } norm_div_t;

    // One restoring division step: returns {quotient bit, new remainder}.
    // The remainder stays below the divisor.
    function automatic logic [SizeW:0] div_step(input logic [SizeW-1:0] r,
                                                input logic b,
                                                input logic [SizeW-1:0] d);
        logic [SizeW:0] t;
        logic [SizeW:0] u;
        t = {r, b};
        u = t - {1'b0, d};
        if (t >= {1'b0, d})
            div_step = {1'b1, u[SizeW-1:0]};
        else
            div_step = {1'b0, t[SizeW-1:0]};
    endfunction

endpackage

// File: sv/heightmap_triangle_height_query_unit.sv
// Heightmap triangle height query unit: banked height store and query pipeline.
//
//  channel | dir | handshake              | contents
//  --------+-----+------------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | load or query word, kind in s_tuser
//  m_*     | out | m_tvalid / m_tready    | height result, on-grid flag in tuser
//  apb     | in  | psel, penable, pready  | cell_size, height_scale, cols, rows
//
// One word is accepted per cycle while the output register is empty or taken;
// a query result reaches the output register through the two 24-step pipelined
// dividers (cell index, final rounding) and the bank read, plane and gain stages.
// The four cell corners are read in the same cycle from four single-port banks
// split by column and row parity; loads write at that same stage, in order.
// The whole pipeline advances while the output register is empty or taken.
// Reset clears control and configuration only; the height store is not
// cleared and needs no clearing pass.
`include "assert_macros.svh"

module heightmap_triangle_height_query_unit #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // grid_col[7:0], grid_row[15:8], raw_height[23:16], query_x[47:24],
    // query_z[71:48]
    input  logic [71:0] s_tdata,
    // command[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // height_out[23:0]
    output logic [23:0] m_tdata,
    // inside_grid[0]
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HC  = (MAX_COLS + 1) / 2;
    localparam int HR  = (MAX_ROWS + 1) / 2;
    localparam int BD  = HC * HR;
    localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
    localparam int QW  = hmtq_pkg::QuotW;

    // Configuration registers.
    logic [15:0] cell_size_reg;
    logic [15:0] height_scale_reg;
    logic [8:0]  cols_used_reg;
    logic [8:0]  rows_used_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg    <= 16'd256;
            height_scale_reg <= 16'd256;
            cols_used_reg    <= 9'd256;
            rows_used_reg    <= 9'd256;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                hmtq_pkg::REG_CELL_SIZE:    cell_size_reg    <= pwdata[15:0];
                hmtq_pkg::REG_HEIGHT_SCALE: height_scale_reg <= pwdata[15:0];
                hmtq_pkg::REG_COLS_USED:    cols_used_reg    <= pwdata[8:0];
                hmtq_pkg::REG_ROWS_USED:    rows_used_reg    <= pwdata[8:0];
                default:                    cell_size_reg    <= cell_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            hmtq_pkg::REG_CELL_SIZE:    prdata = {16'd0, cell_size_reg};
            hmtq_pkg::REG_HEIGHT_SCALE: prdata = {16'd0, height_scale_reg};
            hmtq_pkg::REG_COLS_USED:    prdata = {23'd0, cols_used_reg};
            hmtq_pkg::REG_ROWS_USED:    prdata = {23'd0, rows_used_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Derived configuration values.
    logic [15:0] s_val;
    logic [31:0] nc32;
    logic [31:0] nr32;
    logic [31:0] ncm2;
    logic [31:0] nrm2;
    logic [31:0] len_x_full;
    logic [31:0] len_z_full;

    assign s_val = (cell_size_reg == 16'd0) ? 16'd1 : cell_size_reg;

    always_comb
    begin
        nc32 = {23'd0, cols_used_reg};
        if (nc32 < 32'd2)
            nc32 = 32'd2;
        else if (nc32 > 32'(MAX_COLS))
            nc32 = 32'(MAX_COLS);
        nr32 = {23'd0, rows_used_reg};
        if (nr32 < 32'd2)
            nr32 = 32'd2;
        else if (nr32 > 32'(MAX_ROWS))
            nr32 = 32'(MAX_ROWS);
    end

    assign ncm2       = nc32 - 32'd2;
    assign nrm2       = nr32 - 32'd2;
    assign len_x_full = (nc32 - 32'd1) * {16'd0, s_val};
    assign len_z_full = (nr32 - 32'd1) * {16'd0, s_val};

    // Global advance for the pipeline.
    logic out_vld_reg;
    logic en;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Input register and coordinate dividers.
    hmtq_pkg::coord_div_t da [0:QW];
    logic                 da_vld [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            da_vld[0] <= 1'b0;
        else if (en)
            da_vld[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da[0].is_q <= s_tuser[0];
            da[0].ins  <= (32'(s_tdata[47:24]) <= len_x_full) &&
                          (32'(s_tdata[71:48]) <= len_z_full);
            da[0].col  <= s_tdata[7:0];
            da[0].row  <= s_tdata[15:8];
            da[0].raw  <= s_tdata[23:16];
            da[0].x    <= s_tdata[47:24];
            da[0].z    <= s_tdata[71:48];
            da[0].qx   <= '0;
            da[0].qz   <= '0;
            da[0].rx   <= '0;
            da[0].rz   <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_cdiv
        logic [16:0]          sx;
        logic [16:0]          sz;
        hmtq_pkg::coord_div_t da_next;

        assign sx = hmtq_pkg::div_step(da[k].rx, da[k].x[QW-1-k], s_val);
        assign sz = hmtq_pkg::div_step(da[k].rz, da[k].z[QW-1-k], s_val);

        always_comb
        begin
            da_next              = da[k];
            da_next.rx           = sx[15:0];
            da_next.rz           = sz[15:0];
            da_next.qx[QW-1-k]   = sx[16];
            da_next.qz[QW-1-k]   = sz[16];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                da_vld[k+1] <= 1'b0;
            else if (en)
                da_vld[k+1] <= da_vld[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                da[k+1] <= da_next;
        end
    end

    // Cell index clamp and bank addressing.
    logic          c_vld_reg;
    logic          c_isq_reg;
    logic          c_ins_reg;
    logic          c_i0_reg;
    logic          c_j0_reg;
    logic [15:0]   c_fx_reg;
    logic [15:0]   c_fz_reg;
    logic [7:0]    c_raw_reg;
    logic [AW-1:0] c_addr_reg [4];
    logic [3:0]    c_we_reg;

    logic [31:0]   qx32;
    logic [31:0]   qz32;
    logic          clx;
    logic          clz;
    logic [31:0]   ci;
    logic [31:0]   cj;
    logic [15:0]   fx_n;
    logic [15:0]   fz_n;
    logic [31:0]   lc;
    logic [31:0]   lr;
    logic          lok;
    logic [31:0]   laddr;

    assign qx32 = 32'(da[QW].qx);
    assign qz32 = 32'(da[QW].qz);
    assign clx  = qx32 > ncm2;
    assign clz  = qz32 > nrm2;
    assign ci   = clx ? ncm2 : qx32;
    assign cj   = clz ? nrm2 : qz32;
    // For an on-grid query, a clamped index only occurs on the far edge, where the remainder is zero.
    assign fx_n = clx ? (da[QW].rx + s_val) : da[QW].rx;
    assign fz_n = clz ? (da[QW].rz + s_val) : da[QW].rz;
    assign lc    = 32'(da[QW].col);
    assign lr    = 32'(da[QW].row);
    assign lok   = (lc < 32'(MAX_COLS)) && (lr < 32'(MAX_ROWS));
    assign laddr = (lr >> 1) * 32'(HC) + (lc >> 1);

    for (genvar b = 0; b < 4; b++)
    begin : g_addr
        logic [31:0] colsel;
        logic [31:0] rowsel;
        logic [31:0] qaddr;

        assign colsel = ci + 32'(ci[0] != b[0]);
        assign rowsel = cj + 32'(cj[0] != b[1]);
        assign qaddr  = (rowsel >> 1) * 32'(HC) + (colsel >> 1);

        always_ff @(posedge clk)
        begin
            if (en)
                c_addr_reg[b] <= da[QW].is_q ? qaddr[AW-1:0] : laddr[AW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_we_reg[b] <= 1'b0;
            else if (en)
                c_we_reg[b] <= da_vld[QW] && !da[QW].is_q && lok &&
                               (da[QW].col[0] == b[0]) && (da[QW].row[0] == b[1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= da_vld[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_isq_reg <= da[QW].is_q;
            c_ins_reg <= da[QW].ins;
            c_i0_reg  <= ci[0];
            c_j0_reg  <= cj[0];
            c_fx_reg  <= fx_n;
            c_fz_reg  <= fz_n;
            c_raw_reg <= da[QW].raw;
        end
    end

    // Height banks, indexed by {row parity, column parity}.
    logic [7:0] rd_reg [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [7:0] bank_mem [0:BD-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (c_we_reg[b])
                    bank_mem[c_addr_reg[b]] <= c_raw_reg;
                rd_reg[b] <= bank_mem[c_addr_reg[b]];
            end
        end
    end

    logic        m_vld_reg;
    logic        m_ins_reg;
    logic        m_i0_reg;
    logic        m_j0_reg;
    logic [15:0] m_fx_reg;
    logic [15:0] m_fz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= c_vld_reg && c_isq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_ins_reg <= c_ins_reg;
            m_i0_reg  <= c_i0_reg;
            m_j0_reg  <= c_j0_reg;
            m_fx_reg  <= c_fx_reg;
            m_fz_reg  <= c_fz_reg;
        end
    end

    // Plane terms of the chosen triangle.
    logic [7:0]         h00;
    logic [7:0]         h10;
    logic [7:0]         h01;
    logic [7:0]         h11;
    logic               upper;
    logic signed [8:0]  ga;
    logic signed [8:0]  gb;
    logic               p_vld_reg;
    logic               p_ins_reg;
    logic [23:0]        p0_reg;
    logic signed [25:0] p1_reg;
    logic signed [25:0] p2_reg;

    assign h00   = rd_reg[{m_j0_reg, m_i0_reg}];
    assign h10   = rd_reg[{m_j0_reg, !m_i0_reg}];
    assign h01   = rd_reg[{!m_j0_reg, m_i0_reg}];
    assign h11   = rd_reg[{!m_j0_reg, !m_i0_reg}];
    assign upper = m_fz_reg > m_fx_reg;
    assign ga    = upper ? ($signed({1'b0, h11}) - $signed({1'b0, h01}))
                         : ($signed({1'b0, h10}) - $signed({1'b0, h00}));
    assign gb    = upper ? ($signed({1'b0, h01}) - $signed({1'b0, h00}))
                         : ($signed({1'b0, h11}) - $signed({1'b0, h10}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= m_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ins_reg <= m_ins_reg;
            p0_reg    <= 24'(h00 * s_val);
            p1_reg    <= 26'(ga * $signed({1'b0, m_fx_reg}));
            p2_reg    <= 26'(gb * $signed({1'b0, m_fz_reg}));
        end
    end

    logic signed [26:0] nsum;
    logic               n_vld_reg;
    logic               n_ins_reg;
    logic [23:0]        n_reg;

    assign nsum = $signed({3'd0, p0_reg}) + 27'(p1_reg) + 27'(p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_vld_reg <= 1'b0;
        else if (en)
            n_vld_reg <= p_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_ins_reg <= p_ins_reg;
            n_reg     <= nsum[26] ? 24'd0 : nsum[23:0];
        end
    end

    // Height gain.
    logic        g_vld_reg;
    logic        g_ins_reg;
    logic [39:0] g_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (en)
            g_vld_reg <= n_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_ins_reg  <= n_ins_reg;
            g_prod_reg <= n_reg * height_scale_reg;
        end
    end

    // Rounding divider. The quotient fits 24 bits, so the top 16 bits of the
    // numerator start as the remainder.
    hmtq_pkg::norm_div_t db [0:QW];
    logic                db_vld [0:QW];
    logic [39:0]         num_n;

    assign num_n = g_prod_reg + {25'd0, s_val[15:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            db_vld[0] <= 1'b0;
        else if (en)
            db_vld[0] <= g_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            db[0].ins <= g_ins_reg;
            db[0].num <= num_n;
            db[0].q   <= '0;
            db[0].r   <= num_n[39:24];
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_ndiv
        logic [16:0]         sn;
        hmtq_pkg::norm_div_t db_next;

        assign sn = hmtq_pkg::div_step(db[k].r, db[k].num[QW-1-k], s_val);

        always_comb
        begin
            db_next            = db[k];
            db_next.r          = sn[15:0];
            db_next.q[QW-1-k]  = sn[16];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                db_vld[k+1] <= 1'b0;
            else if (en)
                db_vld[k+1] <= db_vld[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                db[k+1] <= db_next;
        end
    end

    // Output register.
    logic [23:0] out_h_reg;
    logic        out_ins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= db_vld[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_h_reg   <= db[QW].ins ? db[QW].q : 24'd0;
            out_ins_reg <= db[QW].ins;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_h_reg;
    assign m_tuser[0] = out_ins_reg;

    `ASSERT_IMPLY(a_off_grid_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == 24'd0)
    `ASSERT_IMPLY(a_query_no_write, clk, rst_n, c_vld_reg && c_isq_reg, c_we_reg == 4'd0)
    `ASSERT_ALWAYS(a_one_bank_write, clk, rst_n, $onehot0(c_we_reg))

endmodule
